@@ hw/rtl/edc_pkg.sv @@
package edc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_UP   = 3'd1,
    ST_DOWN = 3'd2,
    ST_SLOW = 3'd3,
    ST_WAIT = 3'd4,
    ST_FIRE = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    MOT_STOP       = 3'd0,
    MOT_UP         = 3'd1,
    MOT_DOWN       = 3'd2,
    MOT_CREEP_UP   = 3'd3,
    MOT_CREEP_DOWN = 3'd4
  } motor_e;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_WAIT      = 2'd1;
  localparam logic [1:0] CFG_BLINK     = 2'd2;

  localparam logic [11:0] THRESHOLD_RESET = 12'd1200;
  localparam logic [15:0] WAIT_RESET      = 16'd100;
  localparam logic [15:0] BLINK_RESET     = 16'd50;

  typedef struct packed {
    logic [7:0]  inside_press;
    logic [7:0]  up_press;
    logic [7:0]  down_press;
    logic        fire_sensor;
    logic [3:0]  light_floor;
    logic [11:0] light_value;
  } item_t;

  typedef struct packed {
    logic [2:0] car_state;
    logic [3:0] floor_now;
    logic [2:0] motor_command;
    logic [1:0] arrow;
    logic       alarm;
    logic       any_pending;
  } result_t;

  typedef struct packed {
    logic [11:0] threshold;
    logic [15:0] wait_ticks;
    logic [15:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    state_e      state;
    dir_e        dir;
    logic [3:0]  floor;
    logic [15:0] wait_cnt;
    logic [15:0] blink_cnt;
    logic        alarm;
    logic        fire_sent;
  } ctrl_t;

endpackage

@@ hw/rtl/edc_stream_if.sv @@
interface edc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/edc_tick.sv @@
module edc_tick #(
  parameter int unsigned FLOORS = 8,
  localparam int unsigned IW = $clog2(FLOORS)
) (
  input  edc_pkg::item_t   item_i,
  input  edc_pkg::cfg_t    cfg_i,
  input  edc_pkg::ctrl_t   ctrl_i,
  input  logic [FLOORS-1:0] cab_i,
  input  logic [FLOORS-1:0] up_i,
  input  logic [FLOORS-1:0] dn_i,
  input  logic [11:0]      light_i [FLOORS],
  output edc_pkg::ctrl_t   ctrl_o,
  output logic [FLOORS-1:0] cab_o,
  output logic [FLOORS-1:0] up_o,
  output logic [FLOORS-1:0] dn_o,
  output logic             light_we_o,
  output logic [IW-1:0]    light_idx_o,
  output edc_pkg::result_t res_o
);

  logic [FLOORS-1:0] cab_m, up_m, dn_m, pend_m;
  logic [FLOORS-1:0] above_m, below_m, here_m;
  logic              lf_ok;
  logic [IW-1:0]     lf_idx, cur_idx;
  logic [3:0]        floor_m;
  logic [11:0]       cur_light, f1_light;
  logic              bright_cur, bright_f1;
  logic              any_above, any_below, here_req;
  logic [15:0]       wait_lim, blink_lim, wait_inc, blink_inc;

  always_comb begin
    cab_m = cab_i | FLOORS'(item_i.inside_press);
    up_m  = up_i | FLOORS'(item_i.up_press);
    dn_m  = dn_i | FLOORS'(item_i.down_press);
    pend_m = cab_m | up_m | dn_m;

    lf_ok  = (item_i.light_floor != 4'd0) && (32'(item_i.light_floor) <= FLOORS);
    lf_idx = IW'(item_i.light_floor - 4'd1);
    floor_m = (lf_ok && (item_i.light_value < cfg_i.threshold)) ?
              item_i.light_floor : ctrl_i.floor;
    cur_idx = IW'(floor_m - 4'd1);

    // sample written this tick is seen by the brightness checks
    cur_light = (lf_ok && (lf_idx == cur_idx)) ? item_i.light_value : light_i[cur_idx];
    f1_light  = (lf_ok && (lf_idx == '0)) ? item_i.light_value : light_i[0];
    bright_cur = cur_light > cfg_i.threshold;
    bright_f1  = f1_light > cfg_i.threshold;

    for (int i = 0; i < FLOORS; i++) begin
      above_m[i] = 32'(i) >= 32'(floor_m);
      below_m[i] = 32'(i + 1) < 32'(floor_m);
      here_m[i]  = 32'(i + 1) == 32'(floor_m);
    end
    any_above = |(pend_m & above_m);
    any_below = |(pend_m & below_m);
    here_req  = |(pend_m & here_m);

    wait_lim  = (cfg_i.wait_ticks == 16'd0) ? 16'd1 : cfg_i.wait_ticks;
    blink_lim = (cfg_i.blink_ticks == 16'd0) ? 16'd1 : cfg_i.blink_ticks;
    wait_inc  = ctrl_i.wait_cnt + 16'd1;
    blink_inc = ctrl_i.blink_cnt + 16'd1;

    light_we_o  = lf_ok;
    light_idx_o = lf_idx;
  end

  // next state
  always_comb begin
    ctrl_o = ctrl_i;
    ctrl_o.floor = floor_m;
    cab_o = cab_m;
    up_o  = up_m;
    dn_o  = dn_m;
    if ((ctrl_i.state != edc_pkg::ST_FIRE) && item_i.fire_sensor) begin
      ctrl_o.state = edc_pkg::ST_FIRE;
    end else begin
      case (ctrl_i.state)
        edc_pkg::ST_IDLE: begin
          ctrl_o.dir = edc_pkg::DIR_NONE;
          if (pend_m == '0) begin
            ctrl_o.state = edc_pkg::ST_IDLE;
          end else if (any_above) begin
            ctrl_o.state = edc_pkg::ST_UP;
            ctrl_o.dir   = edc_pkg::DIR_UP;
          end else if (any_below) begin
            ctrl_o.state = edc_pkg::ST_DOWN;
            ctrl_o.dir   = edc_pkg::DIR_DOWN;
          end else begin
            ctrl_o.state    = edc_pkg::ST_WAIT;
            ctrl_o.wait_cnt = '0;
          end
        end
        edc_pkg::ST_UP, edc_pkg::ST_DOWN: begin
          if (here_req) ctrl_o.state = edc_pkg::ST_SLOW;
        end
        edc_pkg::ST_SLOW: begin
          if (bright_cur) begin
            ctrl_o.state    = edc_pkg::ST_WAIT;
            ctrl_o.wait_cnt = '0;
          end
        end
        edc_pkg::ST_WAIT: begin
          ctrl_o.wait_cnt = wait_inc;
          if (wait_inc >= wait_lim) begin
            ctrl_o.wait_cnt = '0;
            cab_o = cab_m & ~here_m;
            // above and below masks exclude this floor, so clearing it leaves them intact
            case (ctrl_i.dir)
              edc_pkg::DIR_UP: begin
                up_o = up_m & ~here_m;
                if (any_above) begin
                  ctrl_o.state = edc_pkg::ST_UP;
                  ctrl_o.dir   = edc_pkg::DIR_UP;
                end else if (any_below) begin
                  ctrl_o.state = edc_pkg::ST_DOWN;
                  ctrl_o.dir   = edc_pkg::DIR_DOWN;
                end else begin
                  ctrl_o.state = edc_pkg::ST_IDLE;
                  ctrl_o.dir   = edc_pkg::DIR_NONE;
                end
              end
              edc_pkg::DIR_DOWN: begin
                dn_o = dn_m & ~here_m;
                if (any_below) begin
                  ctrl_o.state = edc_pkg::ST_DOWN;
                  ctrl_o.dir   = edc_pkg::DIR_DOWN;
                end else if (any_above) begin
                  ctrl_o.state = edc_pkg::ST_UP;
                  ctrl_o.dir   = edc_pkg::DIR_UP;
                end else begin
                  ctrl_o.state = edc_pkg::ST_IDLE;
                  ctrl_o.dir   = edc_pkg::DIR_NONE;
                end
              end
              default: begin
                up_o = up_m & ~here_m;
                dn_o = dn_m & ~here_m;
                ctrl_o.state = edc_pkg::ST_IDLE;
              end
            endcase
          end
        end
        edc_pkg::ST_FIRE: begin
          ctrl_o.blink_cnt = blink_inc;
          if (blink_inc >= blink_lim) begin
            ctrl_o.blink_cnt = '0;
            ctrl_o.alarm     = ~ctrl_i.alarm;
          end
          if (!ctrl_i.fire_sent) begin
            cab_o[0] = 1'b1;
            ctrl_o.fire_sent = 1'b1;
          end
        end
        default: begin
          ctrl_o.state = edc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res_o = '0;
    res_o.car_state   = ctrl_o.state;
    res_o.floor_now   = ctrl_o.floor;
    res_o.any_pending = |(cab_o | up_o | dn_o);
    case (ctrl_o.state)
      edc_pkg::ST_UP: begin
        res_o.motor_command = edc_pkg::MOT_UP;
        res_o.arrow         = edc_pkg::DIR_UP;
      end
      edc_pkg::ST_DOWN: begin
        res_o.motor_command = edc_pkg::MOT_DOWN;
        res_o.arrow         = edc_pkg::DIR_DOWN;
      end
      edc_pkg::ST_SLOW: begin
        res_o.arrow = ctrl_o.dir;
        case (ctrl_o.dir)
          edc_pkg::DIR_UP:   res_o.motor_command = edc_pkg::MOT_CREEP_UP;
          edc_pkg::DIR_DOWN: res_o.motor_command = edc_pkg::MOT_CREEP_DOWN;
          default:           res_o.motor_command = edc_pkg::MOT_STOP;
        endcase
      end
      edc_pkg::ST_FIRE: begin
        res_o.alarm = ctrl_o.alarm;
        if (ctrl_o.floor != 4'd1) begin
          res_o.motor_command = edc_pkg::MOT_DOWN;
        end else if (bright_f1) begin
          res_o.motor_command = edc_pkg::MOT_STOP;
        end else begin
          res_o.motor_command = edc_pkg::MOT_CREEP_DOWN;
        end
      end
      default: begin
        res_o.motor_command = edc_pkg::MOT_STOP;
      end
    endcase
  end

endmodule

@@ hw/rtl/elevator_dispatch_controller_unit.sv @@
// Elevator dispatch controller. Each transaction on in_i is one controller tick: button masks
// are merged into the pending requests, the light sample (if any) is stored and may move the
// current floor, and the idle/up/down/slow/wait/fire state machine takes one step. Every tick
// yields exactly one transaction on out_o. A tick enters an input register, is evaluated
// combinationally by the tick logic against the state registers, and lands in the result
// register, which drives out_o; a new tick is taken every clock cycle while out_o is not
// stalled, and a stalled output holds one result and one more tick before in_i drops ready.
// The per-floor light samples sit in FLOORS flip-flop entries cleared by reset, so no clearing
// pass is needed. Configuration (threshold, wait ticks, blink ticks) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle; an index outside the list is ignored.
module elevator_dispatch_controller_unit #(
  parameter int unsigned FLOORS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  edc_stream_if.sink   in_i,
  edc_stream_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(FLOORS);

  edc_pkg::cfg_t     cfg_q;
  edc_pkg::ctrl_t    ctrl_q, ctrl_d;
  logic [FLOORS-1:0] cab_q, cab_d, up_q, up_d, dn_q, dn_d;
  logic [11:0]       light_q [FLOORS];
  logic              light_we;
  logic [IW-1:0]     light_idx;
  edc_pkg::item_t    item_q;
  logic              in_valid_q;
  edc_pkg::result_t  res_d, res_q;
  logic              out_valid_q;
  logic              advance;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= edc_pkg::THRESHOLD_RESET;
      cfg_q.wait_ticks  <= edc_pkg::WAIT_RESET;
      cfg_q.blink_ticks <= edc_pkg::BLINK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        edc_pkg::CFG_THRESHOLD: cfg_q.threshold   <= cfg_data_i[11:0];
        edc_pkg::CFG_WAIT:      cfg_q.wait_ticks  <= cfg_data_i;
        edc_pkg::CFG_BLINK:     cfg_q.blink_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) item_q <= in_i.data;
  end

  edc_tick #(
    .FLOORS (FLOORS)
  ) u_tick (
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .ctrl_i      (ctrl_q),
    .cab_i       (cab_q),
    .up_i        (up_q),
    .dn_i        (dn_q),
    .light_i     (light_q),
    .ctrl_o      (ctrl_d),
    .cab_o       (cab_d),
    .up_o        (up_d),
    .dn_o        (dn_d),
    .light_we_o  (light_we),
    .light_idx_o (light_idx),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.state     <= edc_pkg::ST_IDLE;
      ctrl_q.dir       <= edc_pkg::DIR_NONE;
      ctrl_q.floor     <= 4'd1;
      ctrl_q.wait_cnt  <= '0;
      ctrl_q.blink_cnt <= '0;
      ctrl_q.alarm     <= 1'b1;
      ctrl_q.fire_sent <= 1'b0;
      cab_q <= '0;
      up_q  <= '0;
      dn_q  <= '0;
      for (int i = 0; i < FLOORS; i++) light_q[i] <= '0;
    end else if (advance) begin
      ctrl_q <= ctrl_d;
      cab_q  <= cab_d;
      up_q   <= up_d;
      dn_q   <= dn_d;
      if (light_we) light_q[light_idx] <= item_q.light_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  a_fire_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.state == edc_pkg::ST_FIRE |=> ctrl_q.state == edc_pkg::ST_FIRE)
    else $error("fire mode left without reset");

  a_fire_sent_in_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.fire_sent |-> ctrl_q.state == edc_pkg::ST_FIRE)
    else $error("floor one request flag set outside fire mode");

  a_floor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.floor >= 4'd1) && (32'(ctrl_q.floor) <= FLOORS))
    else $error("current floor out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while both stages are full");

  a_arrow_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.arrow != 2'd0)) |->
      (res_q.car_state == edc_pkg::ST_UP || res_q.car_state == edc_pkg::ST_DOWN ||
       res_q.car_state == edc_pkg::ST_SLOW))
    else $error("arrow shown while car is not traveling");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FLOORS = 8;
  localparam int unsigned FIDX   = $clog2(FLOORS);

  typedef struct packed {
    edc_pkg::state_e         st;
    edc_pkg::dir_e           dir;
    logic [3:0]              floor;
    logic [7:0]              cab;
    logic [7:0]              hall_up;
    logic [7:0]              hall_dn;
    logic [FLOORS-1:0][11:0] lux;
    logic [15:0]             wait_cnt;
    logic [15:0]             blink_cnt;
    logic                    alarm_lvl;
    logic                    fire_sent;
    logic [11:0]             thr;
    logic [15:0]             wait_lim;
    logic [15:0]             blink_lim;
  } car_model_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  edc_stream_if #(.T(edc_pkg::item_t))   in_if ();
  edc_stream_if #(.T(edc_pkg::result_t)) out_if ();

  elevator_dispatch_controller_unit #(.FLOORS(FLOORS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  car_model_t        tracked_car;
  car_model_t        plan_car;
  edc_pkg::motor_e   plan_motor;
  int                move_wait;
  edc_pkg::item_t    tick_q[$];
  edc_pkg::result_t  status_q[$];
  edc_pkg::result_t  due_status;
  edc_pkg::result_t  want_status;
  int                err_cnt    = 0;
  int                result_cnt = 0;
  int                burst_left = 0;
  int                gap_left   = 0;
  int                ready_cyc  = 0;

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] pend(input car_model_t m);
    return m.cab | m.hall_up | m.hall_dn;
  endfunction

  function automatic logic calls_above(input car_model_t m);
    return (pend(m) >> m.floor) != 8'd0;
  endfunction

  function automatic logic calls_below(input car_model_t m);
    return (pend(m) & ((8'd1 << (m.floor - 4'd1)) - 8'd1)) != 8'd0;
  endfunction

  function automatic logic is_lit(input car_model_t m, input logic [3:0] f);
    return m.lux[FIDX'(f - 4'd1)] > m.thr;
  endfunction

  function automatic void head_on(inout car_model_t m, input logic up_first);
    if (up_first && calls_above(m)) begin
      m.st  = edc_pkg::ST_UP;
      m.dir = edc_pkg::DIR_UP;
    end else if (calls_below(m)) begin
      m.st  = edc_pkg::ST_DOWN;
      m.dir = edc_pkg::DIR_DOWN;
    end else if (calls_above(m)) begin
      m.st  = edc_pkg::ST_UP;
      m.dir = edc_pkg::DIR_UP;
    end else begin
      m.st  = edc_pkg::ST_IDLE;
      m.dir = edc_pkg::DIR_NONE;
    end
  endfunction

  task automatic step_car(inout car_model_t m, input edc_pkg::item_t it,
                          output edc_pkg::result_t r);
    logic [15:0]     lim;
    logic [7:0]      clr;
    edc_pkg::motor_e mot;
    edc_pkg::dir_e   arw;
    logic            alm;
    begin
      m.cab     = m.cab | it.inside_press;
      m.hall_up = m.hall_up | it.up_press;
      m.hall_dn = m.hall_dn | it.down_press;
      if (it.light_floor >= 1 && it.light_floor <= FLOORS) begin
        m.lux[FIDX'(it.light_floor - 4'd1)] = it.light_value;
        if (it.light_value < m.thr) m.floor = it.light_floor;
      end
      if (m.st != edc_pkg::ST_FIRE && it.fire_sensor) begin
        m.st = edc_pkg::ST_FIRE;
      end else begin
        case (m.st)
          edc_pkg::ST_IDLE: begin
            m.dir = edc_pkg::DIR_NONE;
            if (pend(m) != 8'd0) begin
              if (calls_above(m)) begin
                m.st  = edc_pkg::ST_UP;
                m.dir = edc_pkg::DIR_UP;
              end else if (calls_below(m)) begin
                m.st  = edc_pkg::ST_DOWN;
                m.dir = edc_pkg::DIR_DOWN;
              end else begin
                m.st       = edc_pkg::ST_WAIT;
                m.wait_cnt = 16'd0;
              end
            end
          end
          edc_pkg::ST_UP, edc_pkg::ST_DOWN: begin
            if (((pend(m) >> (m.floor - 4'd1)) & 8'd1) != 8'd0) m.st = edc_pkg::ST_SLOW;
          end
          edc_pkg::ST_SLOW: begin
            if (is_lit(m, m.floor)) begin
              m.st       = edc_pkg::ST_WAIT;
              m.wait_cnt = 16'd0;
            end
          end
          edc_pkg::ST_WAIT: begin
            lim        = (m.wait_lim == 16'd0) ? 16'd1 : m.wait_lim;
            m.wait_cnt = m.wait_cnt + 16'd1;
            if (m.wait_cnt >= lim) begin
              m.wait_cnt = 16'd0;
              clr        = 8'd1 << (m.floor - 4'd1);
              m.cab      = m.cab & ~clr;
              case (m.dir)
                edc_pkg::DIR_UP: begin
                  m.hall_up = m.hall_up & ~clr;
                  head_on(m, 1'b1);
                end
                edc_pkg::DIR_DOWN: begin
                  m.hall_dn = m.hall_dn & ~clr;
                  head_on(m, 1'b0);
                end
                default: begin
                  m.hall_up = m.hall_up & ~clr;
                  m.hall_dn = m.hall_dn & ~clr;
                  m.st      = edc_pkg::ST_IDLE;
                end
              endcase
            end
          end
          edc_pkg::ST_FIRE: begin
            lim         = (m.blink_lim == 16'd0) ? 16'd1 : m.blink_lim;
            m.blink_cnt = m.blink_cnt + 16'd1;
            if (m.blink_cnt >= lim) begin
              m.blink_cnt = 16'd0;
              m.alarm_lvl = ~m.alarm_lvl;
            end
            if (!m.fire_sent) begin
              m.cab       = m.cab | 8'd1;
              m.fire_sent = 1'b1;
            end
          end
          default: m.st = edc_pkg::ST_IDLE;
        endcase
      end

      mot = edc_pkg::MOT_STOP;
      arw = edc_pkg::DIR_NONE;
      alm = 1'b0;
      case (m.st)
        edc_pkg::ST_UP: begin
          mot = edc_pkg::MOT_UP;
          arw = edc_pkg::DIR_UP;
        end
        edc_pkg::ST_DOWN: begin
          mot = edc_pkg::MOT_DOWN;
          arw = edc_pkg::DIR_DOWN;
        end
        edc_pkg::ST_SLOW: begin
          if (m.dir == edc_pkg::DIR_UP) mot = edc_pkg::MOT_CREEP_UP;
          else if (m.dir == edc_pkg::DIR_DOWN) mot = edc_pkg::MOT_CREEP_DOWN;
          arw = m.dir;
        end
        edc_pkg::ST_FIRE: begin
          alm = m.alarm_lvl;
          if (m.floor != 4'd1) mot = edc_pkg::MOT_DOWN;
          else if (!is_lit(m, 4'd1)) mot = edc_pkg::MOT_CREEP_DOWN;
        end
        default: ;
      endcase

      r.car_state     = m.st;
      r.floor_now     = m.floor;
      r.motor_command = mot;
      r.arrow         = arw;
      r.alarm         = alm;
      r.any_pending   = (pend(m) != 8'd0);
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch at result %0d: %s", result_cnt, msg);
  endtask

  // queue one tick and follow the car it implies for stimulus shaping
  task automatic push_tick(input logic [7:0] cab_press, input logic [7:0] hall_u,
                           input logic [7:0] hall_d, input logic fire,
                           input logic [3:0] lf, input logic [11:0] lv);
    edc_pkg::item_t   it;
    edc_pkg::result_t r;
    begin
      it.inside_press = cab_press;
      it.up_press     = hall_u;
      it.down_press   = hall_d;
      it.fire_sensor  = fire;
      it.light_floor  = lf;
      it.light_value  = lv;
      step_car(plan_car, it, r);
      plan_motor = edc_pkg::motor_e'(r.motor_command);
      tick_q.push_back(it);
    end
  endtask

  task automatic gen_ticks(input int n, input int noise_pct, input int fire_pct);
    logic [7:0]  ins;
    logic [7:0]  hu;
    logic [7:0]  hd;
    logic [7:0]  onebit;
    logic [3:0]  lf;
    logic [11:0] lv;
    int          roll;
    for (int k = 0; k < n; k++) begin
      ins    = 8'd0;
      hu     = 8'd0;
      hd     = 8'd0;
      roll   = $urandom_range(0, 99);
      onebit = 8'd1 << $urandom_range(0, 7);
      if (roll < 12) begin
        case ($urandom_range(0, 2))
          0: ins = onebit;
          1: hu = onebit;
          default: hd = onebit;
        endcase
      end else if (roll < 15) begin
        ins = 8'($urandom);
        hu  = 8'($urandom);
        hd  = 8'($urandom);
      end else if (roll < 16) begin
        ins = 8'hff;
        hu  = 8'hff;
        hd  = 8'hff;
      end
      lf = 4'd0;
      lv = 12'($urandom);
      if (move_wait > 0) begin
        move_wait--;
      end else begin
        case (plan_motor)
          edc_pkg::MOT_UP, edc_pkg::MOT_DOWN: begin
            // car reaches the next floor: its sensor goes dark
            lf = plan_car.floor;
            if (plan_motor == edc_pkg::MOT_UP && lf < FLOORS) lf = lf + 4'd1;
            if (plan_motor == edc_pkg::MOT_DOWN && lf > 1) lf = lf - 4'd1;
            if (plan_car.thr == 12'd0) lv = 12'd0;
            else if ($urandom_range(0, 3) == 0) lv = plan_car.thr - 12'd1;
            else lv = 12'($urandom_range(0, plan_car.thr - 12'd1));
            move_wait = $urandom_range(0, 3);
          end
          edc_pkg::MOT_CREEP_UP, edc_pkg::MOT_CREEP_DOWN: begin
            // creeping car clears the sensor: bright
            lf = plan_car.floor;
            if (plan_car.thr == 12'hfff) lv = 12'hfff;
            else if ($urandom_range(0, 3) == 0) lv = plan_car.thr + 12'd1;
            else lv = 12'($urandom_range(plan_car.thr + 1, 4095));
            move_wait = $urandom_range(0, 3);
          end
          default: ;
        endcase
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        lf = 4'($urandom_range(0, 15));
        lv = ($urandom_range(0, 3) == 0) ? plan_car.thr : 12'($urandom);
      end
      push_tick(ins, hu, hd, $urandom_range(0, 99) < fire_pct, lf, lv);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      edc_pkg::CFG_THRESHOLD: begin
        tracked_car.thr = val[11:0];
        plan_car.thr    = val[11:0];
      end
      edc_pkg::CFG_WAIT: begin
        tracked_car.wait_lim = val;
        plan_car.wait_lim    = val;
      end
      edc_pkg::CFG_BLINK: begin
        tracked_car.blink_lim = val;
        plan_car.blink_lim    = val;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_if.valid || status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        step_car(tracked_car, in_if.data, due_status);
        status_q.push_back(due_status);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_if.data  <= tick_q.pop_front();
          in_if.valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        result_cnt++;
        if (status_q.size() == 0) begin
          report_mismatch("result transaction with none expected");
        end else begin
          want_status = status_q.pop_front();
          if (out_if.data.car_state !== want_status.car_state)
            report_mismatch($sformatf("car_state got %0d want %0d",
                                      out_if.data.car_state, want_status.car_state));
          if (out_if.data.floor_now !== want_status.floor_now)
            report_mismatch($sformatf("floor_now got %0d want %0d",
                                      out_if.data.floor_now, want_status.floor_now));
          if (out_if.data.motor_command !== want_status.motor_command)
            report_mismatch($sformatf("motor_command got %0d want %0d",
                                      out_if.data.motor_command, want_status.motor_command));
          if (out_if.data.arrow !== want_status.arrow)
            report_mismatch($sformatf("arrow got %0d want %0d",
                                      out_if.data.arrow, want_status.arrow));
          if (out_if.data.alarm !== want_status.alarm)
            report_mismatch($sformatf("alarm got %0d want %0d",
                                      out_if.data.alarm, want_status.alarm));
          if (out_if.data.any_pending !== want_status.any_pending)
            report_mismatch($sformatf("any_pending got %0d want %0d",
                                      out_if.data.any_pending, want_status.any_pending));
        end
      end
      ready_cyc++;
      case ((ready_cyc / 150) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= (ready_cyc % 3 == 0);
        default: out_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin
    #(3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [11:0] thr;
    logic [15:0] wt;
    int          n;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = edc_pkg::CFG_THRESHOLD;
    cfg_data_i   = 16'd0;

    tracked_car           = '0;
    tracked_car.st        = edc_pkg::ST_IDLE;
    tracked_car.dir       = edc_pkg::DIR_NONE;
    tracked_car.floor     = 4'd1;
    tracked_car.alarm_lvl = 1'b1;
    tracked_car.thr       = edc_pkg::THRESHOLD_RESET;
    tracked_car.wait_lim  = edc_pkg::WAIT_RESET;
    tracked_car.blink_lim = edc_pkg::BLINK_RESET;
    plan_car   = tracked_car;
    plan_motor = edc_pkg::MOT_STOP;
    move_wait  = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration, sample edge cases
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'hfff);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd15, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd9, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd3, 12'd1200);
    push_tick(8'h04, 8'h00, 8'h00, 1'b0, 4'd1, 12'hfff);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd2, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd3, 12'd1199);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd3, 12'd1201);
    drain();

    write_reg(edc_pkg::CFG_WAIT, 16'd0);
    write_reg(edc_pkg::CFG_BLINK, 16'd0);
    write_reg(edc_pkg::CFG_THRESHOLD, 16'd2000);
    repeat (4) @(negedge clk_i);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'd0);
    push_tick(8'h00, 8'h00, 8'h01, 1'b0, 4'd0, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd2, 12'd1999);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd1, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd1, 12'hfff);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'd0);
    push_tick(8'h01, 8'h01, 8'h01, 1'b0, 4'd0, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'd0);
    push_tick(8'hff, 8'hff, 8'hff, 1'b0, 4'd8, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd8, 12'd2000);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd8, 12'd2001);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin thr = 12'd1200; wt = 16'd1;     n = 220; end
        1: begin thr = 12'd2000; wt = 16'd3;     n = 220; end
        2: begin thr = 12'd1000; wt = 16'd2;     n = 220; end
        3: begin thr = 12'd20;   wt = 16'd5;     n = 220; end
        4: begin thr = 12'hfff;  wt = 16'd1;     n = 60;  end
        5: begin thr = 12'd0;    wt = 16'd2;     n = 60;  end
        6: begin thr = 12'($urandom); wt = 16'hffff; n = 60; end
        default: begin thr = 12'd1500; wt = 16'd4; n = 220; end
      endcase
      write_reg(edc_pkg::CFG_THRESHOLD, {4'd0, thr});
      write_reg(edc_pkg::CFG_WAIT, wt);
      repeat (4) @(negedge clk_i);
      if (ph == 0) begin
        // hold off until every result is back, then resume
        gen_ticks(n / 2, 10, 0);
        drain();
        gen_ticks(n / 2, 10, 0);
      end else begin
        gen_ticks(n, 10, 0);
      end
      drain();
    end

    // fire mode latches until reset, so it comes last
    write_reg(edc_pkg::CFG_BLINK, 16'd1);
    repeat (4) @(negedge clk_i);
    push_tick(8'h10, 8'h00, 8'h00, 1'b1, 4'd0, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b1, 4'd5, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd1, 12'd0);
    push_tick(8'h00, 8'h00, 8'h00, 1'b0, 4'd1, 12'hfff);
    gen_ticks(120, 10, 50);
    drain();
    write_reg(edc_pkg::CFG_BLINK, 16'd3);
    repeat (4) @(negedge clk_i);
    gen_ticks(120, 10, 50);
    drain();
    write_reg(edc_pkg::CFG_BLINK, 16'd0);
    repeat (4) @(negedge clk_i);
    gen_ticks(120, 10, 50);
    drain();
    write_reg(edc_pkg::CFG_BLINK, 16'hffff);
    repeat (4) @(negedge clk_i);
    gen_ticks(60, 10, 50);
    drain();

    repeat (10) @(negedge clk_i);
    if (status_q.size() != 0) report_mismatch("expected results never arrived");
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/edc_pkg.sv
hw/rtl/edc_stream_if.sv
hw/rtl/edc_tick.sv
hw/rtl/elevator_dispatch_controller_unit.sv
verif/tb_top.sv
